@@ rtl/pcwr_pkg.sv @@
// ----------------------------------------------------------------------------
// pcwr_pkg
// Shared widths, types and register codes of the pixel coordinate router.
// ----------------------------------------------------------------------------
package pcwr_pkg;

	localparam int COORD_BITS   = 12;
	localparam int COLOR_BITS   = 24;
	localparam int NUM_WINDOWS  = 4;
	localparam int WIN_BITS     = 4 * COORD_BITS;
	localparam int CFG_IDX_BITS = 3;
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_FRAME_WIDTH = 3'd0,
		CFG_TOP_WIN     = 3'd1,
		CFG_BOTTOM_WIN  = 3'd2,
		CFG_LEFT_WIN    = 3'd3,
		CFG_RIGHT_WIN   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] y_high;
		logic [COORD_BITS-1:0] y_low;
		logic [COORD_BITS-1:0] x_high;
		logic [COORD_BITS-1:0] x_low;
	} win_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] frame_width;
		win_t [NUM_WINDOWS-1:0] win;
	} cfg_t;

	typedef struct packed {
		logic [COLOR_BITS-1:0] color;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

@@ rtl/pcwr_cfg.sv @@
// ----------------------------------------------------------------------------
// pcwr_cfg
// Configuration register file: frame width and four window bounds.
// ----------------------------------------------------------------------------
module pcwr_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pcwr_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [pcwr_pkg::WIN_BITS-1:0]   cfg_data,
	output pcwr_pkg::cfg_t                  cfg
);
	import pcwr_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FRAME_WIDTH: cfg_q.frame_width <= cfg_data[COORD_BITS-1:0];
				CFG_TOP_WIN:     cfg_q.win[0] <= win_t'(cfg_data);
				CFG_BOTTOM_WIN:  cfg_q.win[1] <= win_t'(cfg_data);
				CFG_LEFT_WIN:    cfg_q.win[2] <= win_t'(cfg_data);
				CFG_RIGHT_WIN:   cfg_q.win[3] <= win_t'(cfg_data);
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/pcwr_front.sv @@
// ----------------------------------------------------------------------------
// pcwr_front
// Accepts pixels, tags them with the column and row counters, advances them.
// ----------------------------------------------------------------------------
module pcwr_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pcwr_pkg::COLOR_BITS-1:0] pixel_color,
	input  logic                           end_of_frame,
	input  logic [pcwr_pkg::COORD_BITS-1:0] frame_width,
	input  pcwr_pkg::fifo_status_t         fifo_status,
	output logic                           push,
	output pcwr_pkg::entry_t               push_entry
);
	import pcwr_pkg::*;

	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;
	logic [COORD_BITS-1:0] col_inc;

	assign in_ready         = !fifo_status.full;
	assign push             = in_valid && in_ready;
	assign push_entry.color = pixel_color;
	assign push_entry.x     = col_q;
	assign push_entry.y     = row_q;
	assign col_inc          = col_q + COORD_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (end_of_frame) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc == frame_width) begin
				col_q <= '0;
				row_q <= row_q + COORD_BITS'(1);
			end else begin
				col_q <= col_inc;
			end
		end
	end

endmodule

@@ rtl/pcwr_fifo.sv @@
// ----------------------------------------------------------------------------
// pcwr_fifo
// Short queue of tagged pixels between the front and back parts.
// ----------------------------------------------------------------------------
module pcwr_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  pcwr_pkg::entry_t       push_entry,
	input  logic                   pop,
	output pcwr_pkg::entry_t       pop_entry,
	output pcwr_pkg::fifo_status_t status
);
	import pcwr_pkg::*;

	entry_t                   mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0] count_q;

	assign status.full  = (count_q == FIFO_CNT_BITS'(FIFO_DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_entry    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_BITS'(1);
			end
		end
	end

endmodule

@@ rtl/pcwr_back.sv @@
// ----------------------------------------------------------------------------
// pcwr_back
// Tests queued pixels against the four windows and holds the result register.
// ----------------------------------------------------------------------------
module pcwr_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pcwr_pkg::cfg_t                  cfg,
	input  pcwr_pkg::fifo_status_t          fifo_status,
	input  pcwr_pkg::entry_t                pop_entry,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pcwr_pkg::COLOR_BITS-1:0] pixel_color_out,
	output logic [pcwr_pkg::COORD_BITS-1:0] pixel_x,
	output logic [pcwr_pkg::COORD_BITS-1:0] pixel_y,
	output logic [pcwr_pkg::NUM_WINDOWS-1:0] edge_hit_mask,
	output logic [pcwr_pkg::NUM_WINDOWS-1:0] edge_last_mask
);
	import pcwr_pkg::*;

	logic                   valid_q;
	entry_t                 entry_q;
	logic [NUM_WINDOWS-1:0] hit_q;
	logic [NUM_WINDOWS-1:0] last_q;
	logic [NUM_WINDOWS-1:0] hit_d;
	logic [NUM_WINDOWS-1:0] last_d;

	assign pop = !fifo_status.empty && (!valid_q || out_ready);

	always_comb begin
		for (int i = 0; i < NUM_WINDOWS; i++) begin
			hit_d[i] = (pop_entry.x >= cfg.win[i].x_low) && (pop_entry.x <= cfg.win[i].x_high)
				&& (pop_entry.y >= cfg.win[i].y_low) && (pop_entry.y <= cfg.win[i].y_high);
			last_d[i] = hit_d[i] && (pop_entry.x == cfg.win[i].x_high)
				&& (pop_entry.y == cfg.win[i].y_high);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			entry_q <= pop_entry;
			hit_q   <= hit_d;
			last_q  <= last_d;
		end
	end

	assign out_valid       = valid_q;
	assign pixel_color_out = entry_q.color;
	assign pixel_x         = entry_q.x;
	assign pixel_y         = entry_q.y;
	assign edge_hit_mask   = hit_q;
	assign edge_last_mask  = last_q;

endmodule

@@ rtl/pixel_coordinate_window_router_core.sv @@
// ----------------------------------------------------------------------------
// pixel_coordinate_window_router_core
// Tags each pixel with its column and row and flags the windows it falls in.
//
// Input channel (in_valid/in_ready): one pixel color and an end-of-frame
// flag per transaction. Output channel (out_valid/out_ready): the color,
// its x/y coordinates, a hit mask and a lower-right-corner mask for the
// top, bottom, left and right windows. Configuration channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 frame width, 1..4 the
// window bounds; cfg_ready is always high, unknown indexes are dropped.
// Write configuration only while no pixel is in flight.
// A pixel accepted on the input is written into the queue, then taken into
// the output register. Throughput: one pixel per cycle unless the receiver
// stalls, set by the single output register that the four-entry queue feeds.
// Reset clears the counters, the configuration and the queue.
// When the receiver stalls, the result register holds and the queue fills;
// in_ready drops once its four entries are taken.
// ----------------------------------------------------------------------------
module pixel_coordinate_window_router_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pcwr_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [pcwr_pkg::WIN_BITS-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pcwr_pkg::COLOR_BITS-1:0]   pixel_color,
	input  logic                              end_of_frame,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pcwr_pkg::COLOR_BITS-1:0]   pixel_color_out,
	output logic [pcwr_pkg::COORD_BITS-1:0]   pixel_x,
	output logic [pcwr_pkg::COORD_BITS-1:0]   pixel_y,
	output logic [pcwr_pkg::NUM_WINDOWS-1:0]  edge_hit_mask,
	output logic [pcwr_pkg::NUM_WINDOWS-1:0]  edge_last_mask
);
	import pcwr_pkg::*;

	cfg_t         cfg;
	fifo_status_t fifo_status;
	logic         push;
	logic         pop;
	entry_t       push_entry;
	entry_t       pop_entry;

	pcwr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pcwr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_color  (pixel_color),
		.end_of_frame (end_of_frame),
		.frame_width  (cfg.frame_width),
		.fifo_status  (fifo_status),
		.push         (push),
		.push_entry   (push_entry)
	);

	pcwr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.status     (fifo_status)
	);

	pcwr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.fifo_status     (fifo_status),
		.pop_entry       (pop_entry),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pixel_color_out (pixel_color_out),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.edge_hit_mask   (edge_hit_mask),
		.edge_last_mask  (edge_last_mask)
	);

endmodule

@@ rtl/pcwr_checker.sv @@
// ----------------------------------------------------------------------------
// pcwr_checker
// Port-level checks of the pixel coordinate router, bound to the top level.
// ----------------------------------------------------------------------------
module pcwr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [pcwr_pkg::COLOR_BITS-1:0]   pixel_color_out,
	input logic [pcwr_pkg::COORD_BITS-1:0]   pixel_x,
	input logic [pcwr_pkg::COORD_BITS-1:0]   pixel_y,
	input logic [pcwr_pkg::NUM_WINDOWS-1:0]  edge_hit_mask,
	input logic [pcwr_pkg::NUM_WINDOWS-1:0]  edge_last_mask
);
	import pcwr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pixel_x) && $stable(pixel_y)
			&& $stable(pixel_color_out) && $stable(edge_hit_mask))
		else $error("output payload changed while stalled");

	a_last_in_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (edge_last_mask & ~edge_hit_mask) == '0)
		else $error("corner flag set outside its window");

	a_no_out_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid straight out of reset");

endmodule

bind pixel_coordinate_window_router_core pcwr_checker u_pcwr_checker (.*);
